// ===== rtl/rmlt_pkg.sv =====
// Shared types and constants of the reentrant monitor lock table.
package rmlt_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;

   localparam int OBJ_W    = 32;
   localparam int THR_W    = 8;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 4;
   localparam int ENTRY_W  = OBJ_W + THR_W + COUNT_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [STATUS_W-1:0] {
      STS_ACQUIRED    = 4'd0,
      STS_REENTERED   = 4'd1,
      STS_BUSY        = 4'd2,
      STS_RELEASED    = 4'd3,
      STS_DECREMENTED = 4'd4,
      STS_NULL        = 4'd5,
      STS_ILLEGAL     = 4'd6,
      STS_FULL        = 4'd7,
      STS_SATURATED   = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      LK_IDLE,
      LK_SCAN,
      LK_DRAIN,
      LK_EXEC
   } lock_state_type;

   typedef struct packed {
      logic [OBJ_W-1:0]   object;
      logic [THR_W-1:0]   owner;
      logic [COUNT_W-1:0] count;
   } entry_type;

endpackage

// ===== rtl/rmlt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rmlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/reentrant_monitor_lock_table_unit.sv =====
// Top level of the reentrant monitor lock table: scan sequencer, decision logic and result register.
//
// Usage:
//  A request (req_type: 0 enter, 1 exit; req_object_ref; req_thread_id) is taken at a
//  clock edge where req_valid is high and req_stall is low. Every request yields exactly
//  one response on rsp_status / rsp_hold_count, handed over when rsp_valid is high and
//  rsp_stall is low.
//  The table lives in a RAM of TABLE_ENTRIES entries with one read port. A single
//  comparator walks the entries one per cycle. From acceptance, a request passes through
//  the scan reads of all TABLE_ENTRIES entries, the last compare, and then the decision
//  and table update, which also loads the result register.
//  A null reference skips the scan and goes straight to the decision. The next request
//  is taken in the cycle after the response is loaded, so the unit takes no new request
//  before the last one has been decided.
//  While the receiver stalls, the finished response is held in the output register and
//  one further request may be accepted and scanned; its table update and response wait
//  until the held response is taken.
//  Synchronous reset clears all entry valid bits and the control state;
//  entry contents are only read once written.
module reentrant_monitor_lock_table_unit #(
   parameter int TABLE_ENTRIES = rmlt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [rmlt_pkg::OBJ_W-1:0]    req_object_ref,
   input  logic [rmlt_pkg::THR_W-1:0]    req_thread_id,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rmlt_pkg::STATUS_W-1:0] rsp_status,
   output logic [rmlt_pkg::COUNT_W-1:0]  rsp_hold_count
);
   import rmlt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   lock_state_type state_ff, state_in;

   logic                     is_exit_ff;
   logic [OBJ_W-1:0]         obj_ff;
   logic [THR_W-1:0]         thr_ff;

   logic [IDX_W-1:0]         scan_idx_ff;
   logic                     cmp_pend_ff;
   logic [IDX_W-1:0]         cmp_idx_ff;

   logic                     hit_ff;
   logic [IDX_W-1:0]         hit_idx_ff;
   logic [THR_W-1:0]         hit_owner_ff;
   logic [COUNT_W-1:0]       hit_count_ff;
   logic                     free_found_ff;
   logic [IDX_W-1:0]         free_idx_ff;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;

   logic                     req_fire;
   logic                     scan_issue;
   logic                     exec_fire;
   logic                     rsp_fire;

   entry_type                rd_entry;
   logic [ENTRY_W-1:0]       rd_data;
   logic                     cmp_valid;
   logic                     cmp_hit;

   status_type               dec_status;
   logic [COUNT_W-1:0]       dec_count;
   logic                     dec_wr;
   logic [IDX_W-1:0]         dec_addr;
   entry_type                dec_entry;
   logic                     dec_set;
   logic                     dec_clr;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid_ff && !rsp_stall;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LK_IDLE: begin
            if (req_valid) begin
               state_in = (req_object_ref == '0) ? LK_EXEC : LK_SCAN;
            end
         end
         LK_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in = LK_DRAIN;
            end
         end
         LK_DRAIN: begin
            state_in = LK_EXEC;
         end
         LK_EXEC: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               state_in = LK_IDLE;
            end
         end
         default: state_in = LK_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_stall  = 1'b1;
      scan_issue = 1'b0;
      exec_fire  = 1'b0;
      unique case (state_ff)
         LK_IDLE:  req_stall  = 1'b0;
         LK_SCAN:  scan_issue = 1'b1;
         LK_DRAIN: ;
         LK_EXEC:  exec_fire  = !(rsp_valid_ff && rsp_stall);
         default:  ;
      endcase
   end

   // ---------------------------------------------------------------- table RAM
   rmlt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (exec_fire && dec_wr),
      .wr_addr (dec_addr),
      .wr_data (dec_entry),
      .rd_en   (scan_issue),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   assign rd_entry  = entry_type'(rd_data);
   assign cmp_valid = valid_ff[cmp_idx_ff];
   assign cmp_hit   = cmp_pend_ff && cmp_valid && (rd_entry.object == obj_ff);

   // ---------------------------------------------------------------- decision
   always_comb begin
      dec_status       = STS_NULL;
      dec_count        = '0;
      dec_wr           = 1'b0;
      dec_addr         = hit_ff ? hit_idx_ff : free_idx_ff;
      dec_entry.object = obj_ff;
      dec_entry.owner  = thr_ff;
      dec_entry.count  = hit_count_ff;
      dec_set          = 1'b0;
      dec_clr          = 1'b0;
      if (obj_ff == '0) begin
         dec_status = STS_NULL;
      end else if (!is_exit_ff) begin
         if (!hit_ff) begin
            if (!free_found_ff) begin
               dec_status = STS_FULL;
            end else begin
               dec_status      = STS_ACQUIRED;
               dec_count       = COUNT_W'(1);
               dec_entry.count = COUNT_W'(1);
               dec_wr          = 1'b1;
               dec_set         = 1'b1;
            end
         end else if (hit_owner_ff != thr_ff) begin
            dec_status = STS_BUSY;
            dec_count  = hit_count_ff;
         end else if (hit_count_ff == COUNT_MAX) begin
            dec_status = STS_SATURATED;
            dec_count  = COUNT_MAX;
         end else begin
            dec_status      = STS_REENTERED;
            dec_count       = hit_count_ff + COUNT_W'(1);
            dec_entry.count = dec_count;
            dec_wr          = 1'b1;
         end
      end else begin
         if (!hit_ff) begin
            dec_status = STS_ILLEGAL;
         end else if (hit_owner_ff != thr_ff || hit_count_ff == '0) begin
            dec_status = STS_ILLEGAL;
            dec_count  = hit_count_ff;
         end else begin
            dec_count       = hit_count_ff - COUNT_W'(1);
            dec_entry.count = dec_count;
            if (dec_count == '0) begin
               dec_status = STS_RELEASED;
               dec_clr    = 1'b1;
            end else begin
               dec_status = STS_DECREMENTED;
               dec_wr     = 1'b1;
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (exec_fire && dec_set) begin
         valid_in[dec_addr] = 1'b1;
      end
      if (exec_fire && dec_clr) begin
         valid_in[dec_addr] = 1'b0;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= LK_IDLE;
         valid_ff      <= '0;
         cmp_pend_ff   <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         scan_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         cmp_pend_ff <= scan_issue;
         if (req_fire) begin
            scan_idx_ff   <= '0;
            hit_ff        <= 1'b0;
            free_found_ff <= 1'b0;
         end else begin
            if (scan_issue) begin
               scan_idx_ff <= scan_idx_ff + IDX_W'(1);
            end
            if (cmp_hit) begin
               hit_ff <= 1'b1;
            end
            // The lowest free entry is the first invalid one met by the scan.
            if (cmp_pend_ff && !cmp_valid && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
         end
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         is_exit_ff <= req_type;
         obj_ff     <= req_object_ref;
         thr_ff     <= req_thread_id;
      end
      cmp_idx_ff <= scan_idx_ff;
      if (cmp_hit) begin
         hit_idx_ff   <= cmp_idx_ff;
         hit_owner_ff <= rd_entry.owner;
         hit_count_ff <= rd_entry.count;
      end
      if (cmp_pend_ff && !cmp_valid && !free_found_ff) begin
         free_idx_ff <= cmp_idx_ff;
      end
      if (exec_fire) begin
         rsp_status_ff <= dec_status;
         rsp_count_ff  <= dec_count;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_hold_count = rsp_count_ff;

   // ---------------------------------------------------------------- checks
   a_acquire_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && dec_status == STS_ACQUIRED) |=> valid_ff[$past(free_idx_ff)])
      else $error("acquired entry was not marked valid");

   a_release_clears_valid: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && dec_status == STS_RELEASED) |=> !valid_ff[$past(hit_idx_ff)])
      else $error("released entry is still valid");

   a_hit_entry_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == LK_EXEC && hit_ff) |-> (valid_ff[hit_idx_ff] && hit_count_ff != '0))
      else $error("matched entry is not a live lock");

   a_exec_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid_ff)
      else $error("decided request produced no response");

   a_scan_single_hit: assert property (@(posedge clock) disable iff (reset)
      (cmp_hit && state_ff != LK_IDLE) |-> !hit_ff)
      else $error("object found in more than one entry");

endmodule
